// ===== sv/pal_pkg.sv =====
// Shared request and status codes, and the sequencer state type, for the array list.
`default_nettype none

package pal_pkg;

  // request kinds as they arrive on the input channel
  typedef enum logic [1:0] {
    KIND_READ   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_MODIFY = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FIRST = 6'b000010,
    S_INS   = 6'b000100,
    S_PUT   = 6'b001000,
    S_REM   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// ===== sv/pal_ram.sv =====
// Entry store: one write port and one read port, read data registered.
`default_nettype none

module pal_ram #(
  parameter int Depth = 64,
  parameter int Aw    = 6
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [Aw-1:0] waddr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [Aw-1:0] raddr_i,
  output      logic [31:0]   rdata_o
);

  logic [31:0] mem_q [Depth];
  logic [31:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, read data registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/pal_seq.sv =====
// Request sequencer: decode, entry shifting through the store, count and result register.
`default_nettype none

module pal_seq
  import pal_pkg::*;
#(
  parameter int Aw = 6
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire logic [1:0]    kind_i,
  input  wire logic [6:0]    position_i,
  input  wire logic [31:0]   value_i,
  input  wire logic [6:0]    cap_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      logic [31:0]   read_value_o,
  output      logic [1:0]    status_o,
  output      logic [6:0]    count_o,
  output      logic          empty_res_o,
  output      logic          full_res_o,
  output      logic          ram_we_o,
  output      logic [Aw-1:0] ram_waddr_o,
  output      logic [31:0]   ram_wdata_o,
  output      logic          ram_re_o,
  output      logic [Aw-1:0] ram_raddr_o,
  input  wire logic [31:0]   ram_rdata_i
);

  state_e      state_q, state_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [6:0]  oldcnt_q, oldcnt_d;
  logic [6:0]  pos_q, pos_d;
  logic [31:0] val_q, val_d;
  kind_e       kind_q, kind_d;
  logic [6:0]  idx_q, idx_d;
  logic [31:0] pend_rd_q, pend_rd_d;
  status_e     pend_st_q, pend_st_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_rd_q, out_rd_d;
  logic [1:0]  out_st_q, out_st_d;
  logic [6:0]  out_cnt_q, out_cnt_d;
  logic        out_empty_q, out_empty_d;
  logic        out_full_q, out_full_d;

  logic [6:0]  waddr_idx, raddr_idx;
  logic [6:0]  pos_m1;
  logic [7:0]  cnt_p1;
  logic        in_list;

  assign pos_m1  = position_i - 7'd1;
  assign cnt_p1  = {1'b0, cnt_q} + 8'd1;
  assign in_list = (position_i != 7'd0) && (position_i <= cnt_q);

  // decode, then step through the store one entry a cycle; accesses in one cycle
  // never touch the same entry, so no forwarding is needed
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    oldcnt_d    = oldcnt_q;
    pos_d       = pos_q;
    val_d       = val_q;
    kind_d      = kind_q;
    idx_d       = idx_q;
    pend_rd_d   = pend_rd_q;
    pend_st_d   = pend_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_rd_d    = out_rd_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    out_empty_d = out_empty_q;
    out_full_d  = out_full_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    waddr_idx   = 7'd0;
    raddr_idx   = 7'd0;
    ram_wdata_o = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pos_d     = position_i;
          val_d     = value_i;
          kind_d    = kind_e'(kind_i);
          oldcnt_d  = cnt_q;
          pend_rd_d = 32'd0;
          pend_st_d = ST_OK;
          state_d   = S_OUT;
          unique case (kind_e'(kind_i))
            KIND_READ: begin
              if (in_list) begin
                ram_re_o  = 1'b1;
                raddr_idx = pos_m1;
                state_d   = S_FIRST;
              end else begin
                pend_st_d = ST_INVALID;
              end
            end
            KIND_INSERT: begin
              if (cnt_q >= cap_i) begin
                pend_st_d = ST_FULL;
              end else if ((position_i == 7'd0) || ({1'b0, position_i} > cnt_p1) ||
                           (position_i > cap_i)) begin
                pend_st_d = ST_INVALID;
              end else begin
                cnt_d = cnt_p1[6:0];
                if ({1'b0, position_i} == cnt_p1) begin
                  // append: nothing to move
                  ram_we_o    = 1'b1;
                  waddr_idx   = pos_m1;
                  ram_wdata_o = value_i;
                end else begin
                  ram_re_o  = 1'b1;
                  raddr_idx = cnt_q - 7'd1;
                  idx_d     = cnt_q - 7'd1;
                  state_d   = S_INS;
                end
              end
            end
            KIND_MODIFY: begin
              if (in_list) begin
                ram_we_o    = 1'b1;
                waddr_idx   = pos_m1;
                ram_wdata_o = value_i;
              end else begin
                pend_st_d = ST_INVALID;
              end
            end
            KIND_REMOVE: begin
              if (in_list) begin
                ram_re_o  = 1'b1;
                raddr_idx = pos_m1;
                idx_d     = pos_m1;
                cnt_d     = cnt_q - 7'd1;
                state_d   = S_FIRST;
              end else begin
                pend_st_d = ST_INVALID;
              end
            end
          endcase
        end
      end

      // capture the word read; a remove then closes the gap
      S_FIRST: begin
        pend_rd_d = ram_rdata_i;
        if ((kind_q == KIND_REMOVE) && (({1'b0, idx_q} + 8'd1) < {1'b0, oldcnt_q})) begin
          ram_re_o  = 1'b1;
          raddr_idx = idx_q + 7'd1;
          state_d   = S_REM;
        end else begin
          state_d = S_OUT;
        end
      end

      // move entry idx+1 down to idx, fetch the next one
      S_REM: begin
        ram_we_o    = 1'b1;
        waddr_idx   = idx_q;
        ram_wdata_o = ram_rdata_i;
        idx_d       = idx_q + 7'd1;
        if (({1'b0, idx_q} + 8'd2) < {1'b0, oldcnt_q}) begin
          ram_re_o  = 1'b1;
          raddr_idx = idx_q + 7'd2;
        end else begin
          state_d = S_OUT;
        end
      end

      // move entry idx up to idx+1, walking down to the insert point
      S_INS: begin
        ram_we_o    = 1'b1;
        waddr_idx   = idx_q + 7'd1;
        ram_wdata_o = ram_rdata_i;
        if (idx_q == (pos_q - 7'd1)) begin
          state_d = S_PUT;
        end else begin
          ram_re_o  = 1'b1;
          raddr_idx = idx_q - 7'd1;
          idx_d     = idx_q - 7'd1;
        end
      end

      // place the new word into the opened slot
      S_PUT: begin
        ram_we_o  = 1'b1;
        waddr_idx = pos_q - 7'd1;
        state_d   = S_OUT;
      end

      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rd_d    = pend_rd_q;
          out_st_d    = pend_st_q;
          out_cnt_d   = cnt_q;
          out_empty_d = (cnt_q == 7'd0);
          out_full_d  = (cnt_q >= cap_i);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign ram_waddr_o = Aw'(waddr_idx);
  assign ram_raddr_o = Aw'(raddr_idx);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= 7'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    oldcnt_q    <= oldcnt_d;
    pos_q       <= pos_d;
    val_q       <= val_d;
    kind_q      <= kind_d;
    idx_q       <= idx_d;
    pend_rd_q   <= pend_rd_d;
    pend_st_q   <= pend_st_d;
    out_rd_q    <= out_rd_d;
    out_st_q    <= out_st_d;
    out_cnt_q   <= out_cnt_d;
    out_empty_q <= out_empty_d;
    out_full_q  <= out_full_d;
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign read_value_o = out_rd_q;
  assign status_o     = out_st_q;
  assign count_o      = out_cnt_q;
  assign empty_res_o  = out_empty_q;
  assign full_res_o   = out_full_q;

endmodule

`default_nettype wire

// ===== sv/positional_array_list.sv =====
// Top level of the positional array list: capacity register, sequencer and entry store.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+-----------------------------------------
//   in       | in_valid_i / in_ready_o  | kind_i, position_i, value_i
//   out      | out_valid_o / out_ready_i| read_value_o, status_o, count_o,
//            |                          | empty_res_o, full_res_o
//   cfg      | cfg_valid_i / cfg_ready_o| cfg_data_i (capacity)
//
// Modify, append and rejected requests go straight to the result; read first captures the word,
// and insert and remove first shift the entries behind the position in the store.
// The store has one read and one write port, so a shift moves one entry a cycle.
// One request is in work at a time; the next is taken while the result waits on out.
// Reset empties the list and sets capacity to 64; the entries need no clearing.
`default_nettype none

module positional_array_list
  import pal_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [6:0]  position_i,
  input  wire logic [31:0] value_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [31:0] read_value_o,
  output      logic [1:0]  status_o,
  output      logic [6:0]  count_o,
  output      logic        empty_res_o,
  output      logic        full_res_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [6:0]  cfg_data_i
);

  localparam int Aw     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CapMax = (DEPTH > 127) ? 127 : DEPTH;

  logic [6:0]    capacity_q;
  logic [6:0]    cap_eff;
  logic          ram_we, ram_re;
  logic [Aw-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  // capacity register, written whenever cfg_valid_i is high
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 7'd64;
    end else if (cfg_valid_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  // clamp capacity into 1..built depth, at most 127
  always_comb begin
    if (capacity_q == 7'd0) begin
      cap_eff = 7'd1;
    end else if (capacity_q > 7'(CapMax)) begin
      cap_eff = 7'(CapMax);
    end else begin
      cap_eff = capacity_q;
    end
  end

  pal_seq #(
    .Aw (Aw)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .cap_i        (cap_eff),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o),
    .empty_res_o  (empty_res_o),
    .full_res_o   (full_res_o),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  pal_ram #(
    .Depth (DEPTH),
    .Aw    (Aw)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== sv/pal_checker.sv =====
// Port-level checks for the positional array list, bound to the top level.
`default_nettype none

module pal_checker
  import pal_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] read_value_o,
  input wire logic [1:0]  status_o,
  input wire logic [6:0]  count_o,
  input wire logic        empty_res_o,
  input wire logic        full_res_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o) &&
      $stable(status_o) && $stable(count_o))
    else $error("result changed while stalled");

  // one request in work at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in work");

  // empty flag follows the count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (empty_res_o == (count_o == 7'd0)))
    else $error("empty flag disagrees with count");

  // failed requests return no word, and a full rejection reports a full list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |->
      (read_value_o == 32'd0) && ((status_o != ST_FULL) || full_res_o))
    else $error("failed request result inconsistent");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

`default_nettype wire
